/* hw/rtl/u8d_pkg.sv */
// Package for the UTF-8 code point decoder: result and job types, byte class
// masks and value constants. Depends on nothing; every file but u8d_ifs imports it.
package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned USED_W = 3;
  localparam int unsigned ENT_N  = 4;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] PAY2_MASK  = 8'h1F;
  localparam logic [7:0] PAY3_MASK  = 8'h0F;
  localparam logic [7:0] PAY4_MASK  = 8'h07;

  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] QMARK   = 21'h00003F;

  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RAW  = 2'd1,
    ST_SURR = 2'd2
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [USED_W-1:0] used;
    status_t           st;
  } entry_t;

  // One job holds every result caused by one input byte; last is the index
  // of the final result.
  typedef struct packed {
    logic [1:0]            last;
    entry_t [ENT_N-1:0]    ent;
  } job_t;

endpackage

/* hw/rtl/u8d_ifs.sv */
// Handshake interfaces for the byte input channel and the result channel.
// Depends on nothing.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  bytes_used;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output code_point, output bytes_used, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input bytes_used, input status,
                  input last_of_run, output ready);
endinterface

/* hw/rtl/u8d_front.sv */
// Front end: accepts bytes, tracks the open sequence and builds one job with
// all results a byte causes. Depends on u8d_pkg.
module u8d_front import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [7:0] pend_r [3];
  logic [7:0] pend_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] exp_r, exp_nxt;
  logic       acc;
  logic [2:0] num;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = acc && (num != 3'd0);

  always_comb begin
    logic [CP_W-1:0] cp;
    logic            done;
    logic [7:0]      pmask;
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    pend_nxt = pend_r;
    push_job = '0;
    num      = 3'd0;
    done     = 1'b0;
    cp       = '0;
    case (exp_r)
      LEN2:    pmask = PAY2_MASK;
      LEN3:    pmask = PAY3_MASK;
      default: pmask = PAY4_MASK;
    endcase

    if (cnt_r != 2'd0) begin
      if ((in_byte & CONT_MASK) == CONT_CODE) begin
        done = 1'b1;
        if (({1'b0, cnt_r} + 3'd1) >= exp_r) begin
          cp = {13'd0, pend_r[0] & pmask};
          for (int i = 1; i < 3; i++) begin
            if (i < int'(cnt_r)) cp = {cp[CP_W-7:0], pend_r[i][5:0]};
          end
          cp = {cp[CP_W-7:0], in_byte[5:0]};
          if (cp >= SURR_LO && cp <= SURR_HI) begin
            push_job.ent[0] = '{cp: QMARK, used: 3'd1, st: ST_SURR};
            num = 3'd1;
            for (int i = 1; i < 3; i++) begin
              if (i < int'(cnt_r)) begin
                push_job.ent[num[1:0]] = '{cp: {13'd0, pend_r[i]}, used: 3'd1, st: ST_RAW};
                num = num + 3'd1;
              end
            end
            push_job.ent[num[1:0]] = '{cp: {13'd0, in_byte}, used: 3'd1, st: ST_RAW};
            num = num + 3'd1;
          end else begin
            push_job.ent[0] = '{cp: cp, used: exp_r, st: ST_OK};
            num = 3'd1;
          end
          cnt_nxt = 2'd0;
          exp_nxt = 3'd0;
        end else begin
          if (cnt_r == 2'd1) pend_nxt[1] = in_byte;
          else               pend_nxt[2] = in_byte;
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        // Broken sequence: flush everything buffered as raw bytes.
        for (int i = 0; i < 3; i++) begin
          if (i < int'(cnt_r)) begin
            push_job.ent[num[1:0]] = '{cp: {13'd0, pend_r[i]}, used: 3'd1, st: ST_RAW};
            num = num + 3'd1;
          end
        end
        cnt_nxt = 2'd0;
        exp_nxt = 3'd0;
      end
    end

    if (!done) begin
      if (in_byte[7] == 1'b0) begin
        push_job.ent[num[1:0]] = '{cp: {13'd0, in_byte}, used: 3'd1, st: ST_OK};
        num = num + 3'd1;
      end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
        pend_nxt[0] = in_byte;
        cnt_nxt     = 2'd1;
        exp_nxt     = 3'd2;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
        pend_nxt[0] = in_byte;
        cnt_nxt     = 2'd1;
        exp_nxt     = 3'd3;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
        pend_nxt[0] = in_byte;
        cnt_nxt     = 2'd1;
        exp_nxt     = 3'd4;
      end else begin
        push_job.ent[num[1:0]] = '{cp: {13'd0, in_byte}, used: 3'd1, st: ST_RAW};
        num = num + 3'd1;
      end
    end

    push_job.last = num[1:0] - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      exp_r <= 3'd0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) pend_r <= pend_nxt;
  end

endmodule

/* hw/rtl/u8d_queue.sv */
// Short job queue between front and back end, register based.
// Depends on u8d_pkg.
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output job_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_job;
  end

endmodule

/* hw/rtl/u8d_back.sv */
// Back end: holds one job in the output register and hands out its results
// one per transaction. Depends on u8d_pkg.
module u8d_back import u8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  job_t        q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic [2:0]  bytes_used,
  output logic [1:0]  status,
  output logic        last_of_run
);

  logic       busy_r;
  job_t       job_r;
  logic [1:0] idx_r;
  logic       take, at_last;
  entry_t     cur;

  assign cur         = job_r.ent[idx_r];
  assign at_last     = (idx_r == job_r.last);
  assign take        = busy_r && out_ready;
  assign pop         = q_nonempty && (!busy_r || (take && at_last));
  assign out_valid   = busy_r;
  assign code_point  = cur.cp;
  assign bytes_used  = cur.used;
  assign status      = cur.st;
  assign last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (take) begin
      if (at_last) busy_r <= 1'b0;
      else         idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_head;
  end

endmodule

/* hw/rtl/utf8_code_point_decoder.sv */
// Top level of the UTF-8 code point decoder: front end, job queue, back end.
// Depends on u8d_pkg, u8d_ifs, u8d_front, u8d_queue and u8d_back.
//
//   channel   direction   payload                                         
//   in_if     sink        in_byte[7:0]                                    
//   out_if    source      code_point[20:0] bytes_used[2:0] status[1:0]    
//                         last_of_run                                     
//
// A byte is taken in every cycle in which the job queue has room, so the
// input side runs at one byte per cycle. The back end sends one result per
// cycle while the output is ready; a byte that causes k results holds it for
// k transfers, and a byte that only extends an open sequence costs nothing.
// The queue (QUEUE_DEPTH jobs) absorbs replay bursts and output back pressure.
// Reset is synchronous and active low; there is no clearing pass, and the
// block accepts bytes in the first cycle after reset is released.
module utf8_code_point_decoder import u8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst_n,
  u8d_in_if.sink    in_if,
  u8d_out_if.source out_if
);

  logic q_full, q_nonempty, push, pop;
  job_t push_job, q_head;

  // The front end decodes each accepted byte in the same cycle and turns it
  // into a job that lists every result that byte causes.
  u8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_byte  (in_if.in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Jobs wait here so that a stalled output does not stop decoding at once.
  u8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // The back end walks through the results of one job, one transaction each.
  u8d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_nonempty  (q_nonempty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .code_point  (out_if.code_point),
    .bytes_used  (out_if.bytes_used),
    .status      (out_if.status),
    .last_of_run (out_if.last_of_run)
  );

endmodule

/* hw/rtl/u8d_checker.sv */
// Port level checks for the UTF-8 code point decoder, bound to the top level.
// Depends on u8d_pkg and utf8_code_point_decoder.
module u8d_checker import u8d_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [2:0]  bytes_used,
  input logic [1:0]  status,
  input logic        last_of_run
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point) &&
      $stable(bytes_used) && $stable(status) && $stable(last_of_run))
    else $error("result changed while stalled");

  // A surrogate marker is a single '?' and is always followed by replays.
  a_surr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_SURR) |->
      (code_point == QMARK) && (bytes_used == 3'd1) && !last_of_run)
    else $error("bad surrogate marker");

  // Raw bytes are single bytes.
  a_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_RAW) |-> (bytes_used == 3'd1) && (code_point < 21'd256))
    else $error("bad raw byte result");

  // A well formed one-byte result is ASCII; longer ones are 2 to 4 bytes.
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OK) |->
      ((bytes_used == 3'd1) && (code_point < 21'd128)) ||
      (bytes_used == 3'd2) || (bytes_used == 3'd3) || (bytes_used == 3'd4))
    else $error("bad well formed result");

endmodule

bind utf8_code_point_decoder u8d_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .code_point  (out_if.code_point),
  .bytes_used  (out_if.bytes_used),
  .status      (out_if.status),
  .last_of_run (out_if.last_of_run)
);

/* sim/tb_top.sv */
// Self-checking testbench for utf8_code_point_decoder: directed and random byte
// streams, a cycle-free decoder predictor and a per-field result check.
// Depends on u8d_pkg, u8d_ifs and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned RANDOM_BYTES = 124;
  // Longest run of cycles with no transaction on either side before giving up.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Cycles to watch the output after the last expected result has arrived.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [2:0]  LEN4         = 3'd4;

  // Hand-picked text: extremes of ASCII, a stray continuation, a 11111xxx lead,
  // a plain and an overlong 2-byte form, a 3-byte and a 4-byte surrogate, the
  // largest 4-byte value, and two sequences broken by a foreign byte.
  localparam logic [7:0] DIRECTED_TEXT [26] = '{
    8'h00, 8'h7F, 8'hBF, 8'hFF,
    8'hC2, 8'hA9,
    8'hC0, 8'h80,
    8'hED, 8'hA0, 8'h80,
    8'hF0, 8'h8D, 8'hBF, 8'hBF,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hE2, 8'h82, 8'h41,
    8'hF0, 8'h90, 8'h80, 8'hFF
  };

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [USED_W-1:0] used;
    status_t           st;
    logic              last;
  } cp_result_t;

  logic clk;
  logic rst_n;

  u8d_in_if  in_ch();
  u8d_out_if out_ch();

  utf8_code_point_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Bytes still to be offered, and decoded results that the block still owes.
  logic [7:0]  text_bytes[$];
  cp_result_t  cp_results_due[$];

  int unsigned total_bytes;
  int unsigned bytes_taken;
  int unsigned results_seen;
  int unsigned raw_seen;
  int unsigned surr_seen;
  int unsigned err_count;
  int unsigned quiet_cycles;
  logic        in_fire;

  // Decoder state as the predictor sees it: the buffered lead and
  // continuation bytes, how many are held, and the length of the open sequence.
  logic [7:0]  held [3];
  int unsigned held_n;
  logic [2:0]  seq_len;

  // Results caused by the byte being decoded, gathered before the last one is
  // known and marked.
  cp_result_t  run_buf [4];
  int unsigned run_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      note_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                           results_seen, name, got, want));
  endtask

  function automatic void add_result(input logic [CP_W-1:0] cp, input int unsigned used,
                                     input status_t st);
    run_buf[run_len] = '{cp: cp, used: USED_W'(used), st: st, last: 1'b0};
    run_len++;
  endfunction

  // Works out every result that one byte causes and queues them in order.
  function automatic void decode_byte(input logic [7:0] b);
    logic [CP_W-1:0] acc;
    run_len = 0;
    if (held_n != 0 && (b & CONT_MASK) == CONT_CODE) begin
      if (held_n + 1 >= seq_len) begin
        // The sequence is complete: rebuild the value from the lead payload
        // and six bits per continuation.
        case (seq_len)
          LEN2:    acc = CP_W'(held[0] & PAY2_MASK);
          LEN3:    acc = CP_W'(held[0] & PAY3_MASK);
          default: acc = CP_W'(held[0] & PAY4_MASK);
        endcase
        for (int i = 1; i < held_n; i++)
          acc = (acc << 6) | CP_W'(held[i][5:0]);
        acc = (acc << 6) | CP_W'(b[5:0]);
        if (acc >= SURR_LO && acc <= SURR_HI) begin
          // A surrogate value is replaced and its continuations come back raw.
          add_result(QMARK, 1, ST_SURR);
          for (int i = 1; i < held_n; i++)
            add_result(CP_W'(held[i]), 1, ST_RAW);
          add_result(CP_W'(b), 1, ST_RAW);
        end else begin
          add_result(acc, seq_len, ST_OK);
        end
        held_n  = 0;
        seq_len = '0;
      end else begin
        held[held_n] = b;
        held_n++;
      end
    end else begin
      // A byte that cannot extend the open sequence flushes it raw first.
      for (int i = 0; i < held_n; i++)
        add_result(CP_W'(held[i]), 1, ST_RAW);
      held_n  = 0;
      seq_len = '0;
      if (!b[7]) begin
        add_result(CP_W'(b), 1, ST_OK);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        held[0] = b;
        held_n  = 1;
        seq_len = LEN2;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        held[0] = b;
        held_n  = 1;
        seq_len = LEN3;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        held[0] = b;
        held_n  = 1;
        seq_len = LEN4;
      end else begin
        // Stray continuation or a 11111xxx lead.
        add_result(CP_W'(b), 1, ST_RAW);
      end
    end
    for (int i = 0; i < run_len; i++) begin
      run_buf[i].last = (i == run_len - 1);
      cp_results_due.insert(cp_results_due.size(), run_buf[i]);
    end
  endfunction

  // Appends one byte to the text still to be offered.
  function automatic void queue_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  // Queues a lead for a sequence of len bytes (len 1 is plain ASCII) with
  // random payload, followed by conts random continuation bytes.
  function automatic void push_seq(input int unsigned len, input int unsigned conts);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       queue_byte({1'b0, r[6:0]});
      2:       queue_byte(LEAD2_CODE | (r & ~LEAD2_MASK));
      3:       queue_byte(LEAD3_CODE | (r & ~LEAD3_MASK));
      default: queue_byte(LEAD4_CODE | (r & ~LEAD4_MASK));
    endcase
    for (int i = 0; i < conts; i++)
      queue_byte(CONT_CODE | (8'($urandom) & ~CONT_MASK));
  endfunction

  // Driver. Both sides change at the falling edge. The run is split into four
  // pacing phases by the share of bytes already taken: free running, a mostly
  // idle sender, a mostly stalled receiver, and both at a moderate rate.
  always @(negedge clk) begin
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= '0;
      out_ch.ready  <= 1'b0;
    end else begin
      case ((bytes_taken * 4) / total_bytes)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // A new byte is offered only once the previous transaction completed,
      // so valid never drops while a byte is waiting.
      if (!in_ch.valid || in_fire) begin
        if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.in_byte <= text_bytes.pop_front();
          in_ch.valid   <= 1'b1;
        end else begin
          in_ch.valid   <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. Both channels are sampled at the rising edge. Each accepted byte
  // feeds the predictor; each accepted result is checked against the oldest
  // outstanding one.
  always @(posedge clk) begin
    cp_result_t want;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte);
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (cp_results_due.size() == 0) begin
          note_error($sformatf("unexpected result cp=0x%0h used=%0d status=%0d",
                               out_ch.code_point, out_ch.bytes_used, out_ch.status));
        end else begin
          want = cp_results_due.pop_front();
          check_field("code_point", out_ch.code_point, want.cp);
          check_field("bytes_used", out_ch.bytes_used, want.used);
          check_field("status", out_ch.status, want.st);
          check_field("last_of_run", out_ch.last_of_run, want.last);
          if (want.st == ST_RAW)
            raw_seen++;
          if (want.st == ST_SURR)
            surr_seen++;
        end
        results_seen++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: the run is stuck if neither side moves for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT)
      @(negedge clk);
    $display("Stalled for %0d cycles with %0d results outstanding.",
             STALL_LIMIT, cp_results_due.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    held_n        = 0;
    seq_len       = '0;
    bytes_taken   = 0;
    results_seen  = 0;
    raw_seen      = 0;
    surr_seen     = 0;
    err_count     = 0;

    foreach (DIRECTED_TEXT[i])
      queue_byte(DIRECTED_TEXT[i]);

    // Mostly well-formed text with random content, a share of surrogate
    // encodings, truncated sequences that the next byte breaks, and noise.
    while (text_bytes.size() < $size(DIRECTED_TEXT) + RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(1, 4);
        push_seq(len, len - 1);
      end else if (pick < 75) begin
        queue_byte(8'hED);
        queue_byte({3'b101, 5'($urandom)});
        queue_byte(CONT_CODE | (8'($urandom) & ~CONT_MASK));
      end else if (pick < 90) begin
        len = $urandom_range(2, 4);
        push_seq(len, $urandom_range(0, len - 2));
      end else begin
        queue_byte(8'($urandom));
      end
    end
    total_bytes = text_bytes.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every byte taken and every predicted result delivered, then a short
    // quiet window to catch anything extra.
    while (bytes_taken != total_bytes || cp_results_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Decoded %0d bytes into %0d results: %0d raw bytes, %0d surrogates replaced,",
             bytes_taken, results_seen, raw_seen, surr_seen);
    $display("under free-running, idle-sender, stalled-receiver and mixed pacing.");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches.", err_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_ifs.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_code_point_decoder.sv
hw/rtl/u8d_checker.sv
sim/tb_top.sv
